[src/sca_pkg.sv]
// Shared constants, register codes and types for the shape coverage alpha blend unit.
package sca_pkg;

    // Coordinate register width (two's complement)
    localparam int COORD_BITS = 16;

    // Fixed field widths
    localparam int PIX_W      = 12;
    localparam int FRAME_W    = 13;
    localparam int COLOR_W    = 32;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 56;
    localparam int MODE_W     = 2;

    // Derived coordinate arithmetic widths
    localparam int CMP_W = COORD_BITS + 2;   // signed compare / difference width
    localparam int MAG_W = COORD_BITS + 1;   // absolute difference width
    localparam int RAD_W = COORD_BITS - 1;   // non-negative radius width
    localparam int SQ_W  = 2 * RAD_W;        // square of a radius-sized value

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_SHAPE_MODE   = 3'd2,
        REG_COORD_A      = 3'd3,
        REG_COORD_B      = 3'd4,
        REG_COORD_C      = 3'd5,
        REG_COORD_D      = 3'd6,
        REG_FILL_COLOR   = 3'd7
    } cfg_reg_t;

    // Primitive codes
    localparam logic [MODE_W-1:0] SHAPE_POINT  = 2'd0;
    localparam logic [MODE_W-1:0] SHAPE_RECT   = 2'd1;
    localparam logic [MODE_W-1:0] SHAPE_CIRCLE = 2'd2;

    // Reset values
    localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // Coverage terms handed from the coverage stage to the blend stage
    typedef struct packed {
        logic            hit_flat;   // point or rectangle hit, clipped
        logic            circ_ok;    // circle bounding box passed, clipped
        logic [SQ_W-1:0] dx2;
        logic [SQ_W-1:0] dy2;
        logic [SQ_W-1:0] r2;
    } cover_t;

endpackage

[src/sca_cover.sv]
// Coverage stage: clipping, point/rectangle tests and circle squares, registered.
module sca_cover (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 load,
    input  logic                                 in_valid,
    input  logic [sca_pkg::PIX_W-1:0]            pix_x,
    input  logic [sca_pkg::PIX_W-1:0]            pix_y,
    input  logic [sca_pkg::COLOR_W-1:0]          dest_color,
    input  logic [sca_pkg::FRAME_W-1:0]          frame_width,
    input  logic [sca_pkg::FRAME_W-1:0]          frame_height,
    input  logic [sca_pkg::MODE_W-1:0]           shape_mode,
    input  logic [sca_pkg::COORD_BITS-1:0]       coord_a,
    input  logic [sca_pkg::COORD_BITS-1:0]       coord_b,
    input  logic [sca_pkg::COORD_BITS-1:0]       coord_c,
    input  logic [sca_pkg::COORD_BITS-1:0]       coord_d,
    output logic                                 out_valid,
    output sca_pkg::cover_t                      out_cover,
    output logic [sca_pkg::COLOR_W-1:0]          out_dest
);
    import sca_pkg::*;

    logic signed [CMP_W-1:0] xs, ys, as, bs, cs, ds;
    logic signed [CMP_W-1:0] dxs, dys;
    logic [MAG_W-1:0]        dx_mag, dy_mag, r_ext;
    logic [RAD_W-1:0]        dx_n, dy_n, r_n;
    logic                    in_frame;
    cover_t                  cover_next;

    logic                    valid_reg;
    cover_t                  cover_reg;
    logic [COLOR_W-1:0]      dest_reg;

    // Coverage terms for the item in the input register
    always_comb begin
        xs = signed'({{(CMP_W-PIX_W){1'b0}}, pix_x});
        ys = signed'({{(CMP_W-PIX_W){1'b0}}, pix_y});
        as = signed'({{(CMP_W-COORD_BITS){coord_a[COORD_BITS-1]}}, coord_a});
        bs = signed'({{(CMP_W-COORD_BITS){coord_b[COORD_BITS-1]}}, coord_b});
        cs = signed'({{(CMP_W-COORD_BITS){coord_c[COORD_BITS-1]}}, coord_c});
        ds = signed'({{(CMP_W-COORD_BITS){coord_d[COORD_BITS-1]}}, coord_d});

        in_frame = ({1'b0, pix_x} < frame_width) && ({1'b0, pix_y} < frame_height);

        // absolute distances to the circle center
        dxs    = xs - as;
        dys    = ys - bs;
        dx_mag = dxs[CMP_W-1] ? MAG_W'(-dxs) : MAG_W'(dxs);
        dy_mag = dys[CMP_W-1] ? MAG_W'(-dys) : MAG_W'(dys);
        r_n    = coord_c[RAD_W-1:0];
        r_ext  = {2'b00, r_n};
        dx_n   = dx_mag[RAD_W-1:0];
        dy_n   = dy_mag[RAD_W-1:0];

        cover_next.dx2 = SQ_W'(dx_n) * SQ_W'(dx_n);
        cover_next.dy2 = SQ_W'(dy_n) * SQ_W'(dy_n);
        cover_next.r2  = SQ_W'(r_n) * SQ_W'(r_n);

        cover_next.hit_flat = 1'b0;
        cover_next.circ_ok  = 1'b0;
        case (shape_mode)
            SHAPE_POINT: begin
                cover_next.hit_flat = in_frame && (xs == as) && (ys == bs);
            end
            SHAPE_RECT: begin
                cover_next.hit_flat = in_frame && (xs >= as) && (xs < cs)
                                      && (ys >= bs) && (ys < ds);
            end
            SHAPE_CIRCLE: begin
                cover_next.circ_ok = in_frame && !coord_c[COORD_BITS-1]
                                     && (dx_mag <= r_ext) && (dy_mag <= r_ext);
            end
            default: begin
                cover_next.hit_flat = 1'b0;
            end
        endcase
    end

    // Stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
        end
        if (load) begin
            cover_reg <= cover_next;
            dest_reg  <= dest_color;
        end
    end

    assign out_valid = valid_reg;
    assign out_cover = cover_reg;
    assign out_dest  = dest_reg;

endmodule

[src/sca_blend.sv]
// Blend stage: final circle compare, per-channel alpha blend and result register.
module sca_blend (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 load,
    input  logic                                 in_valid,
    input  sca_pkg::cover_t                      in_cover,
    input  logic [sca_pkg::COLOR_W-1:0]          in_dest,
    input  logic [sca_pkg::COLOR_W-1:0]          fill_color,
    output logic                                 out_valid,
    output logic                                 out_write_enable,
    output logic [sca_pkg::COLOR_W-1:0]          out_color
);
    import sca_pkg::*;

    logic [SQ_W:0]        dist2;
    logic                 covered;
    logic [CH_W-1:0]      alpha;
    logic [CH_W-1:0]      dc, sc, q;
    logic signed [CH_W:0] diff;
    logic signed [2*CH_W+1:0] prod;
    logic [2*CH_W-1:0]    mag;
    logic [2*CH_W:0]      qsum;
    logic [COLOR_W-1:0]   blended;

    logic                 valid_reg;
    logic                 we_reg;
    logic [COLOR_W-1:0]   color_reg;

    // Coverage decision and blend
    always_comb begin
        dist2   = {1'b0, in_cover.dx2} + {1'b0, in_cover.dy2};
        covered = in_cover.hit_flat || (in_cover.circ_ok && (dist2 <= {1'b0, in_cover.r2}));

        alpha   = fill_color[COLOR_W-1 -: CH_W];
        blended = {in_dest[COLOR_W-1 -: CH_W], {(COLOR_W-CH_W){1'b0}}};
        dc = '0; sc = '0; q = '0; diff = '0; prod = '0; mag = '0; qsum = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            dc   = in_dest[ch*CH_W +: CH_W];
            sc   = fill_color[ch*CH_W +: CH_W];
            diff = signed'({1'b0, sc}) - signed'({1'b0, dc});
            prod = diff * signed'({1'b0, alpha});
            mag  = prod[2*CH_W+1] ? (2*CH_W)'(-prod) : (2*CH_W)'(prod);
            // exact floor(mag / 255) for mag below 65280 (255 * 256)
            qsum = {1'b0, mag} + (2*CH_W+1)'(1) + (2*CH_W+1)'(mag >> CH_W);
            q    = qsum[2*CH_W-1 -: CH_W];
            blended[ch*CH_W +: CH_W] = prod[2*CH_W+1] ? (dc - q) : (dc + q);
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
        end
        if (load) begin
            we_reg    <= covered;
            color_reg <= covered ? blended : in_dest;
        end
    end

    assign out_valid        = valid_reg;
    assign out_write_enable = we_reg;
    assign out_color        = color_reg;

endmodule

[src/shape_coverage_alpha_blend_unit.sv]
// Top level of the shape coverage alpha blend unit: registers, input stage, pipeline control.
//
// Takes one pixel item per clock while s_tready is high (column, row, current RGBA) and
// returns one result per item: a write enable that is high when the configured point,
// half-open rectangle or filled circle covers the pixel inside the frame, and the color to
// write back (the fill color blended over the pixel by the fill alpha, destination alpha
// kept; the pixel unchanged when not covered). The pipeline is three registers deep: the
// input, coverage and result registers, in that order; one item per cycle is sustained
// while m_tready stays high. The circle squares and the blend multiplies each sit in their
// own stage. s_tready drops only when every stage holds an item and m_tready is low.
// Configuration is written through cfg_valid/cfg_ready/cfg_index/cfg_data (always ready)
// and must only change while idle.
module shape_coverage_alpha_blend_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sca_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sca_pkg::CFG_DATA_W-1:0]       cfg_data,
    // pixel input
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [sca_pkg::IN_DATA_W-1:0]        s_tdata,   // pix_x, pix_y, dest_color
    // result output
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [sca_pkg::COLOR_W-1:0]          m_tdata,   // result_color
    output logic                                 m_tuser    // write_enable
);
    import sca_pkg::*;

    logic [FRAME_W-1:0]    frame_width_reg, frame_height_reg;
    logic [MODE_W-1:0]     shape_mode_reg;
    logic [COORD_BITS-1:0] coord_a_reg, coord_b_reg, coord_c_reg, coord_d_reg;
    logic [COLOR_W-1:0]    fill_color_reg;

    logic                  in_valid_reg;
    logic [PIX_W-1:0]      pix_x_reg, pix_y_reg;
    logic [COLOR_W-1:0]    dest_reg;

    logic                  load_in, load_cov, load_out;
    logic                  cov_valid;
    cover_t                cov_terms;
    logic [COLOR_W-1:0]    cov_dest;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            shape_mode_reg   <= SHAPE_POINT;
            coord_a_reg      <= '0;
            coord_b_reg      <= '0;
            coord_c_reg      <= '0;
            coord_d_reg      <= '0;
            fill_color_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FRAME_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FRAME_W-1:0];
                REG_SHAPE_MODE:   shape_mode_reg   <= cfg_data[MODE_W-1:0];
                REG_COORD_A:      coord_a_reg      <= cfg_data[COORD_BITS-1:0];
                REG_COORD_B:      coord_b_reg      <= cfg_data[COORD_BITS-1:0];
                REG_COORD_C:      coord_c_reg      <= cfg_data[COORD_BITS-1:0];
                REG_COORD_D:      coord_d_reg      <= cfg_data[COORD_BITS-1:0];
                REG_FILL_COLOR:   fill_color_reg   <= cfg_data[COLOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Stage enables: a stage loads when it is empty or its contents move on
    assign load_out = !m_tvalid || m_tready;
    assign load_cov = !cov_valid || load_out;
    assign load_in  = !in_valid_reg || load_cov;
    assign s_tready = load_in;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (load_in) begin
            in_valid_reg <= s_tvalid;
        end
        if (load_in) begin
            pix_x_reg <= s_tdata[PIX_W-1:0];
            pix_y_reg <= s_tdata[2*PIX_W-1:PIX_W];
            dest_reg  <= s_tdata[2*PIX_W+COLOR_W-1:2*PIX_W];
        end
    end

    sca_cover u_cover (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (load_cov),
        .in_valid     (in_valid_reg),
        .pix_x        (pix_x_reg),
        .pix_y        (pix_y_reg),
        .dest_color   (dest_reg),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .shape_mode   (shape_mode_reg),
        .coord_a      (coord_a_reg),
        .coord_b      (coord_b_reg),
        .coord_c      (coord_c_reg),
        .coord_d      (coord_d_reg),
        .out_valid    (cov_valid),
        .out_cover    (cov_terms),
        .out_dest     (cov_dest)
    );

    sca_blend u_blend (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .load             (load_out),
        .in_valid         (cov_valid),
        .in_cover         (cov_terms),
        .in_dest          (cov_dest),
        .fill_color       (fill_color_reg),
        .out_valid        (m_tvalid),
        .out_write_enable (m_tuser),
        .out_color        (m_tdata)
    );

    // Input is only held off when the whole pipeline is full and the output stalls
    a_backpressure_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && cov_valid && in_valid_reg))
        else $error("input stalled with room in the pipeline");

    // The unused shape code never produces a write
    a_unused_mode_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && shape_mode_reg != SHAPE_POINT && shape_mode_reg != SHAPE_RECT
         && shape_mode_reg != SHAPE_CIRCLE) |-> !m_tuser)
        else $error("write enable with unused shape mode");

    // Opaque fill replaces the color channels exactly
    a_opaque_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser && fill_color_reg[COLOR_W-1 -: CH_W] == 8'hFF)
        |-> (m_tdata[NUM_CH*CH_W-1:0] == fill_color_reg[NUM_CH*CH_W-1:0]))
        else $error("opaque fill did not replace color channels");

endmodule

[test/shape_coverage_alpha_blend_checker.sv]
// Checker for the shape coverage alpha blend unit: tracks config, predicts each pixel, compares.
module shape_coverage_alpha_blend_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [sca_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sca_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [sca_pkg::IN_DATA_W-1:0]  s_tdata,    // pix_x, pix_y, dest_color
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [sca_pkg::COLOR_W-1:0]    m_tdata,    // result_color
    input  logic                           m_tuser,    // write_enable
    output int                             error_count,
    output int                             pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import sca_pkg::*;

    localparam int ALPHA_MAX = 255;

    typedef struct packed {
        logic               write_enable;
        logic [COLOR_W-1:0] color;
    } pixel_result_t;

    // Shadow copy of the register file
    logic [FRAME_W-1:0]           frame_width;
    logic [FRAME_W-1:0]           frame_height;
    logic [MODE_W-1:0]            shape_mode;
    logic signed [COORD_BITS-1:0] coord_a;
    logic signed [COORD_BITS-1:0] coord_b;
    logic signed [COORD_BITS-1:0] coord_c;
    logic signed [COORD_BITS-1:0] coord_d;
    logic [COLOR_W-1:0]           fill_color;

    // Results owed by the block, oldest first
    pixel_result_t expected_pixels[$];

    // Coverage test against the shape, then per-channel blend of the fill color
    function automatic pixel_result_t predict_pixel(input logic [IN_DATA_W-1:0] item);
        longint             x;
        longint             y;
        longint             a;
        longint             b;
        longint             c;
        longint             d;
        longint             dx;
        longint             dy;
        logic [COLOR_W-1:0] dst;
        logic [COLOR_W-1:0] mix;
        logic               hit;
        int                 alpha;
        int                 dc;
        int                 sc;
        int                 v;
        x   = longint'(item[PIX_W-1:0]);
        y   = longint'(item[2*PIX_W-1:PIX_W]);
        dst = item[IN_DATA_W-1:2*PIX_W];
        a   = longint'(coord_a);
        b   = longint'(coord_b);
        c   = longint'(coord_c);
        d   = longint'(coord_d);
        hit = 1'b0;
        // off-frame pixels never hit; a zero-sized frame hits nothing
        if (x < longint'(frame_width) && y < longint'(frame_height)) begin
            case (shape_mode)
                SHAPE_POINT: hit = (x == a) && (y == b);
                SHAPE_RECT: hit = (x >= a) && (x < c) && (y >= b) && (y < d);
                SHAPE_CIRCLE: begin
                    // negative radius covers nothing
                    if (c >= 0) begin
                        dx  = (x >= a) ? x - a : a - x;
                        dy  = (y >= b) ? y - b : b - y;
                        hit = (dx * dx + dy * dy) <= c * c;
                    end
                end
                default: hit = 1'b0;
            endcase
        end
        if (!hit) begin
            return '{1'b0, dst};
        end
        // destination alpha is kept, color channels move toward the fill
        mix   = {dst[COLOR_W-1 -: CH_W], {(COLOR_W-CH_W){1'b0}}};
        alpha = int'(fill_color[COLOR_W-1 -: CH_W]);
        for (int ch = 0; ch < NUM_CH; ch++) begin
            dc = int'(dst[ch*CH_W +: CH_W]);
            sc = int'(fill_color[ch*CH_W +: CH_W]);
            v  = dc + ((sc - dc) * alpha) / ALPHA_MAX;
            mix[ch*CH_W +: CH_W] = v[CH_W-1:0];
        end
        return '{1'b1, mix};
    endfunction

    // Track config writes, check each accepted result in full and queue each accepted item at each edge
    always @(posedge aclk) begin : watch
        pixel_result_t want;
        int            errs;
        errs = 0;
        if (!aresetn) begin
            frame_width  = FRAME_WIDTH_RST;
            frame_height = FRAME_HEIGHT_RST;
            shape_mode   = SHAPE_POINT;
            coord_a      = '0;
            coord_b      = '0;
            coord_c      = '0;
            coord_d      = '0;
            fill_color   = '0;
            expected_pixels.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width  = cfg_data[FRAME_W-1:0];
                    REG_FRAME_HEIGHT: frame_height = cfg_data[FRAME_W-1:0];
                    REG_SHAPE_MODE:   shape_mode   = cfg_data[MODE_W-1:0];
                    REG_COORD_A:      coord_a      = cfg_data[COORD_BITS-1:0];
                    REG_COORD_B:      coord_b      = cfg_data[COORD_BITS-1:0];
                    REG_COORD_C:      coord_c      = cfg_data[COORD_BITS-1:0];
                    REG_COORD_D:      coord_d      = cfg_data[COORD_BITS-1:0];
                    REG_FILL_COLOR:   fill_color   = cfg_data[COLOR_W-1:0];
                    default: ;
                endcase
            end
            // compare before queuing, so a stray result never matches a fresh item
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    $error("result with no item pending: write_enable %0b result_color %08h",
                           m_tuser, m_tdata);
                    errs++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_tuser !== want.write_enable) begin
                        $error("write_enable mismatch: expected %0b, actual %0b",
                               want.write_enable, m_tuser);
                        errs++;
                    end
                    if (m_tdata !== want.color) begin
                        $error("result_color mismatch: expected %08h, actual %08h",
                               want.color, m_tdata);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_pixels.push_back(predict_pixel(s_tdata));
            end
        end
        error_count   <= error_count + errs;
        pending_count <= expected_pixels.size();
    end

endmodule

[test/shape_coverage_alpha_blend_unit_test.sv]
// Testbench top for the shape coverage alpha blend unit: clock, reset, stimulus and verdict.
module shape_coverage_alpha_blend_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sca_pkg::*;

    // mode 3 is not a primitive and covers nothing
    localparam logic [MODE_W-1:0] SHAPE_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 24;
    localparam int PHASE_ITEMS   = 42;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int PIX_MAX       = (1 << PIX_W) - 1;

    typedef struct {
        logic [FRAME_W-1:0]           width;
        logic [FRAME_W-1:0]           height;
        logic [MODE_W-1:0]            mode;
        logic signed [COORD_BITS-1:0] a;
        logic signed [COORD_BITS-1:0] b;
        logic signed [COORD_BITS-1:0] c;
        logic signed [COORD_BITS-1:0] d;
        logic [COLOR_W-1:0]           color;
    } shape_cfg_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;    // pix_x, pix_y, dest_color
    logic                  m_tvalid;
    logic                  m_tready;
    logic [COLOR_W-1:0]    m_tdata;    // result_color
    logic                  m_tuser;    // write_enable

    int cycle_count = 0;
    int failures;
    int pending;
    bit no_idle;
    bit hold_request;

    shape_coverage_alpha_blend_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    shape_coverage_alpha_blend_checker blend_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .error_count   (failures),
        .pending_count (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Run watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int idle_gap();
        int r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Pixel coordinate scattered around a center, clipped to the 12-bit range
    function automatic logic [PIX_W-1:0] near_coord(input int center, input int spread);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) begin
            v = 0;
        end
        if (v > PIX_MAX) begin
            v = PIX_MAX;
        end
        return v[PIX_W-1:0];
    endfunction

    function automatic shape_cfg_t make_shape(input int w, input int h, input logic [1:0] m,
                                              input int a, input int b, input int c,
                                              input int d, input logic [31:0] color);
        shape_cfg_t s;
        s.width  = w[FRAME_W-1:0];
        s.height = h[FRAME_W-1:0];
        s.mode   = m;
        s.a      = a[COORD_BITS-1:0];
        s.b      = b[COORD_BITS-1:0];
        s.c      = c[COORD_BITS-1:0];
        s.d      = d[COORD_BITS-1:0];
        s.color  = color;
        return s;
    endfunction

    // Random junk above the register's width; the block must drop it
    function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
                                                        input int keep);
        logic [CFG_DATA_W-1:0] m;
        m = (CFG_DATA_W'(1) << keep) - 1;
        return ($urandom & ~m) | (v & m);
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
                              input logic [COLOR_W-1:0] dest);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {dest, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stop offering and wait for every owed result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Registers only change with the pipeline empty
    task automatic apply_config(input shape_cfg_t s);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(REG_FRAME_WIDTH, with_junk(CFG_DATA_W'(s.width), FRAME_W));
        write_reg(REG_FRAME_HEIGHT, with_junk(CFG_DATA_W'(s.height), FRAME_W));
        write_reg(REG_SHAPE_MODE, with_junk(CFG_DATA_W'(s.mode), MODE_W));
        write_reg(REG_COORD_A, with_junk(CFG_DATA_W'(s.a), COORD_BITS));
        write_reg(REG_COORD_B, with_junk(CFG_DATA_W'(s.b), COORD_BITS));
        write_reg(REG_COORD_C, with_junk(CFG_DATA_W'(s.c), COORD_BITS));
        write_reg(REG_COORD_D, with_junk(CFG_DATA_W'(s.d), COORD_BITS));
        write_reg(REG_FILL_COLOR, s.color);
    endtask

    // Result side: random back-pressure, plus one long hold-off on request
    initial begin : result_sink
        int gap;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else begin
                gap = idle_gap();
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        shape_cfg_t       s;
        int               pick;
        int               cx;
        int               cy;
        int               span_x;
        int               span_y;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;

        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_FRAME_WIDTH;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        no_idle      = 1'b0;
        hold_request = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset config: point at origin, transparent black fill
        send_pixel(12'd0, 12'd0, 32'h12345678);
        send_pixel(12'd1, 12'd0, 32'hFFFFFFFF);
        send_pixel(12'd639, 12'd479, 32'h00000000);
        send_pixel(12'd4095, 12'd4095, 32'hA5A5A5A5);

        // one-pixel frame
        apply_config(make_shape(1, 1, SHAPE_POINT, 0, 0, 0, 0, 32'hFF0000FF));
        send_pixel(12'd0, 12'd0, 32'h00000000);
        send_pixel(12'd1, 12'd0, 32'h00000000);

        // largest legal frame, point in the far corner, opaque fill
        apply_config(make_shape(4096, 4096, SHAPE_POINT, 4095, 4095, 0, 0, 32'hFF112233));
        send_pixel(12'd4095, 12'd4095, 32'hFFFFFFFF);
        send_pixel(12'd4094, 12'd4095, 32'h00000000);

        // oversized frame, rectangle spanning the whole coordinate range
        apply_config(make_shape(8191, 8191, SHAPE_RECT, -32768, -32768, 32767, 32767,
                                32'h80FF00FF));
        send_pixel(12'd0, 12'd0, 32'h00FF00FF);
        send_pixel(12'd4095, 12'd4095, 32'hFF00FF00);

        // zero width frame hides everything
        apply_config(make_shape(0, 4096, SHAPE_RECT, -32768, -32768, 32767, 32767,
                                32'hFFFFFFFF));
        send_pixel(12'd0, 12'd0, 32'h00000000);

        // empty rectangle
        apply_config(make_shape(640, 480, SHAPE_RECT, 10, 5, 10, 20, 32'hFFFFFFFF));
        send_pixel(12'd10, 12'd5, 32'h00000000);

        // half-open edges of a small rectangle
        apply_config(make_shape(640, 480, SHAPE_RECT, 5, 5, 8, 8, 32'hC0102030));
        send_pixel(12'd5, 12'd5, 32'h80F0E0D0);
        send_pixel(12'd7, 12'd7, 32'h00000000);
        send_pixel(12'd8, 12'd7, 32'h00000000);
        send_pixel(12'd7, 12'd8, 32'h00000000);

        // zero radius covers only the center
        apply_config(make_shape(640, 480, SHAPE_CIRCLE, 100, 100, 0, 0, 32'h7F0080FF));
        send_pixel(12'd100, 12'd100, $urandom);
        send_pixel(12'd101, 12'd100, $urandom);

        // negative radius
        apply_config(make_shape(640, 480, SHAPE_CIRCLE, 100, 100, -1, 0, 32'hFFFFFFFF));
        send_pixel(12'd100, 12'd100, $urandom);

        // largest radius from the origin
        apply_config(make_shape(4096, 4096, SHAPE_CIRCLE, 0, 0, 32767, 0, 32'h01FEDCBA));
        send_pixel(12'd4095, 12'd4095, $urandom);

        // circle rim: 3-4-5 is on, one step out is off
        apply_config(make_shape(640, 480, SHAPE_CIRCLE, 10, 10, 5, 0, 32'h40C0C0C0));
        send_pixel(12'd13, 12'd14, $urandom);
        send_pixel(12'd14, 12'd14, $urandom);

        // unused mode
        apply_config(make_shape(640, 480, SHAPE_UNUSED, 0, 0, 100, 100, 32'hFFFFFFFF));
        send_pixel(12'd0, 12'd0, $urandom);
        send_pixel(12'd50, 12'd50, $urandom);

        // random shapes, pixels mostly around the shape
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            pick     = $urandom_range(0, 9);
            s.width  = (pick == 0) ? FRAME_W'($urandom) : FRAME_W'($urandom_range(1, 4096));
            pick     = $urandom_range(0, 9);
            s.height = (pick == 0) ? FRAME_W'($urandom) : FRAME_W'($urandom_range(1, 4096));
            pick     = $urandom_range(0, 9);
            s.mode   = (pick < 3) ? SHAPE_POINT : (pick < 6) ? SHAPE_RECT :
                       (pick < 9) ? SHAPE_CIRCLE : SHAPE_UNUSED;
            s.a      = COORD_BITS'(int'($urandom_range(0, 4300)) - 100);
            s.b      = COORD_BITS'(int'($urandom_range(0, 4300)) - 100);
            if (s.mode == SHAPE_CIRCLE) begin
                s.c = COORD_BITS'(($urandom_range(0, 9) == 0) ?
                                  -int'($urandom_range(1, 300)) :
                                  int'($urandom_range(0, 400)));
            end else begin
                s.c = COORD_BITS'(int'(s.a) + int'($urandom_range(0, 600)) - 20);
            end
            s.d = COORD_BITS'(int'(s.b) + int'($urandom_range(0, 600)) - 20);
            if ($urandom_range(0, 7) == 0) begin
                s.a = COORD_BITS'($urandom);
                s.b = COORD_BITS'($urandom);
                s.c = COORD_BITS'($urandom);
                s.d = COORD_BITS'($urandom);
            end
            s.color = $urandom;
            pick    = $urandom_range(0, 3);
            if (pick == 0) begin
                s.color[COLOR_W-1 -: CH_W] = 8'h00;
            end else if (pick == 1) begin
                s.color[COLOR_W-1 -: CH_W] = 8'hFF;
            end
            apply_config(s);

            // one phase at full rate, with a long result stall to back up the input
            if (phase == 3) begin
                no_idle      = 1'b1;
                hold_request = 1'b1;
            end else begin
                no_idle = 1'b0;
            end

            // region of interest for this shape
            cx     = int'(s.a);
            cy     = int'(s.b);
            span_x = 3;
            span_y = 3;
            if (s.mode == SHAPE_RECT) begin
                cx     = (int'(s.a) + int'(s.c)) / 2;
                cy     = (int'(s.b) + int'(s.d)) / 2;
                span_x = ((int'(s.c) > int'(s.a)) ? int'(s.c) - int'(s.a) :
                          int'(s.a) - int'(s.c)) / 2 + 4;
                span_y = ((int'(s.d) > int'(s.b)) ? int'(s.d) - int'(s.b) :
                          int'(s.b) - int'(s.d)) / 2 + 4;
            end else if (s.mode == SHAPE_CIRCLE) begin
                span_x = ((s.c < 0) ? -int'(s.c) : int'(s.c)) + 4;
                span_y = span_x;
            end
            if (span_x > 2048) begin
                span_x = 2048;
            end
            if (span_y > 2048) begin
                span_y = 2048;
            end

            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(0, 7);
                if (pick < 2) begin
                    px = PIX_W'($urandom);
                    py = PIX_W'($urandom);
                end else if (pick == 2) begin
                    px = near_coord(int'(s.width), 2);
                    py = near_coord(int'(s.height), 2);
                end else begin
                    px = near_coord(cx, span_x);
                    py = near_coord(cy, span_y);
                end
                send_pixel(px, py, $urandom);
                if ($urandom_range(0, 59) == 0) begin
                    wait_drained();
                end
            end
        end

        // drain, then give a stray result time to show up
        no_idle = 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
